>>> sv/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> sv/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// Used by the cell, the chain and the top level; depends on nothing.
`timescale 1ns / 1ps
package ffha_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 20;
    localparam int PAGE_BYTES   = 4096;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int PG_SH  = $clog2(PAGE_BYTES);
    localparam int OFF_W  = 25;
    localparam int SIZE_W = 25;
    localparam int KEY_W  = 26;
    localparam int MIN_PAGES = 4;

    localparam logic [SIZE_W-1:0] SPACE_CAP = 25'h100_0000;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;

    localparam logic [1:0] CFG_HEAP_BASE = 2'd0;
    localparam logic [1:0] CFG_LIMIT     = 2'd1;
    localparam logic [1:0] CFG_INITIAL   = 2'd2;
    localparam logic [1:0] CFG_MIN_SPLIT = 2'd3;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_ZERO     = 3'd1;
    localparam logic [2:0] STS_OOM      = 3'd2;
    localparam logic [2:0] STS_OUTSIDE  = 3'd3;
    localparam logic [2:0] STS_NOTBLOCK = 3'd4;
    localparam logic [2:0] STS_DOUBLE   = 3'd5;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
        logic              free;
    } entry_t;

    typedef enum logic [2:0] {
        CO_NONE,
        CO_WRITE,
        CO_SHR,
        CO_SHL,
        CO_SCAN0,
        CO_SCAN
    } cell_op_t;

    typedef enum logic {
        KM_FIT,
        KM_MATCH
    } key_mode_t;

    typedef struct packed {
        cell_op_t          op;
        logic [IDX_W-1:0]  idx;
        entry_t            wdata;
        logic              wr_off;
        logic              wr_size;
        logic              wr_free;
        key_mode_t         mode;
        logic [KEY_W-1:0]  key;
        logic [IDX_W-1:0]  rd_idx;
    } cell_ctl_t;

    typedef struct packed {
        entry_t rd;
        logic   hit;
    } chain_stat_t;

endpackage

>>> sv/ffha_cell.sv
// One table entry of the allocator with its scan token.
// Depends on ffha_pkg.
`timescale 1ns / 1ps
module ffha_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ffha_pkg::IDX_W-1:0]   my_idx,
    input  ffha_pkg::cell_ctl_t          ctl,
    input  ffha_pkg::entry_t             left_ent,
    input  ffha_pkg::entry_t             right_ent,
    input  logic                         tok_in,
    output ffha_pkg::entry_t             ent,
    output logic                         tok_out,
    output logic                         hit,
    output ffha_pkg::entry_t             rd_ent
);
    import ffha_pkg::*;

    entry_t            ent_reg;
    entry_t            ent_next;
    logic              tok_reg;
    logic              tok_next;
    logic [KEY_W-1:0]  pay_start;
    logic              match;

    always_comb
    begin
        ent_next = ent_reg;
        tok_next = 1'b0;
        case (ctl.op)
            CO_WRITE:
            begin
                if (my_idx == ctl.idx)
                begin
                    if (ctl.wr_off)  ent_next.off  = ctl.wdata.off;
                    if (ctl.wr_size) ent_next.size = ctl.wdata.size;
                    if (ctl.wr_free) ent_next.free = ctl.wdata.free;
                end
            end
            CO_SHR:
            begin
                if (my_idx > ctl.idx)
                    ent_next = left_ent;
                else if (my_idx == ctl.idx)
                    ent_next = ctl.wdata;
            end
            CO_SHL:
            begin
                if (my_idx >= ctl.idx)
                    ent_next = right_ent;
            end
            CO_SCAN0: tok_next = (my_idx == '0);
            CO_SCAN:  tok_next = tok_in;
            default:  ;
        endcase
    end

    // A free lookup matches the payload start, an allocation a free entry that fits.
    assign pay_start = {1'b0, ent_reg.off} + KEY_W'(HEADER_BYTES);
    assign match = (ctl.mode == KM_FIT) ? (ent_reg.free && ({1'b0, ent_reg.size} >= ctl.key))
                                        : (pay_start == ctl.key);

    assign hit     = tok_reg & match;
    assign tok_out = tok_reg;
    assign ent     = ent_reg;
    assign rd_ent  = (my_idx == ctl.rd_idx) ? ent_reg : '0;

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= 1'b0;
        else
            tok_reg <= tok_next;
    end

endmodule

>>> sv/ffha_chain.sv
// Row of allocator cells in address order, with the read select and hit merge.
// Depends on ffha_pkg and ffha_cell.
`timescale 1ns / 1ps
module ffha_chain (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ffha_pkg::cell_ctl_t   ctl,
    output ffha_pkg::chain_stat_t stat
);
    import ffha_pkg::*;

    entry_t ents  [MAX_BLOCKS];
    entry_t rds   [MAX_BLOCKS];
    logic   toks  [MAX_BLOCKS];
    logic   hits  [MAX_BLOCKS];

    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   tin;

        if (i == 0)
        begin : g_first
            assign left_e = '0;
            assign tin    = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = ents[i-1];
            assign tin    = toks[i-1];
        end

        if (i == MAX_BLOCKS - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = ents[i+1];
        end

        ffha_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .my_idx    (IDX_W'(i)),
            .ctl       (ctl),
            .left_ent  (left_e),
            .right_ent (right_e),
            .tok_in    (tin),
            .ent       (ents[i]),
            .tok_out   (toks[i]),
            .hit       (hits[i]),
            .rd_ent    (rds[i])
        );
    end

    // Only one cell is selected and only one holds the token, so OR merges them.
    always_comb
    begin
        stat = '0;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            stat.rd  = stat.rd | rds[i];
            stat.hit = stat.hit | hits[i];
        end
    end

endmodule

>>> sv/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: command sequencer and cell row.
// Depends on ffha_pkg, ffha_chain and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage: the block keeps an address-ordered table of heap blocks in a row of
// cells. A command transfer happens at a clock edge where start is high and
// busy is low; cmd, req_size and free_addr are sampled there. Every command
// gives exactly one result transfer: done is high for one cycle with
// payload_addr, status, used_bytes and free_bytes, and the receiver cannot
// stall it. Configuration is written through cfg_we, cfg_index and cfg_data
// at any edge with cfg_we high, and must only change while the block is idle.
// Initialize, unknown commands and commands rejected at once go straight to
// the final state. Allocate and free pass a scan token along the cells, one
// cell per cycle, until it hits or passes the last entry, then run their
// update states (growth, take and split for allocate; check, merge and the
// left shifts that remove merged entries for free) and the final state. done
// is registered from the final state, so the result transfer is made in the
// first cycle in which busy is low again.
// Reset clears the block count, heap size and totals; the table contents are
// not cleared, since only entries below the block count are ever read.
module first_fit_heap_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [23:0] req_size,
    input  logic [31:0] free_addr,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [31:0] payload_addr,
    output logic [2:0]  status,
    output logic [24:0] used_bytes,
    output logic [24:0] free_bytes
);
    import ffha_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_TAKE,
        S_SPLIT,
        S_GROW1,
        S_GROW2,
        S_FCHK,
        S_FRIGHT,
        S_FLEFT,
        S_SHIFTL,
        S_FIN
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          cmd_reg, cmd_next;
    logic [SIZE_W-1:0]   s_reg, s_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [CNT_W-1:0]    c_reg, c_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    entry_t              ent_reg, ent_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SIZE_W-1:0]   end_reg, end_next;
    logic [SIZE_W-1:0]   used_reg, used_next;
    logic [SIZE_W-1:0]   freet_reg, freet_next;
    logic [SIZE_W-1:0]   added_reg, added_next;
    logic                merge_r_reg, merge_r_next;
    logic [IDX_W-1:0]    shl_idx_reg, shl_idx_next;
    logic [1:0]          shl_n_reg, shl_n_next;
    logic [2:0]          sts_reg, sts_next;
    logic [31:0]         addr_reg, addr_next;
    logic                done_reg;
    logic [31:0]         pa_reg;
    logic [2:0]          st_reg;
    logic [24:0]         ub_reg, fb_reg;

    logic [31:0]         base_reg;
    logic [24:0]         limit_reg;
    logic [24:0]         initial_reg;
    logic [12:0]         min_split_reg;

    cell_ctl_t           ctl;
    chain_stat_t         stat;

    // Arithmetic helpers.
    logic [SIZE_W-1:0]   rounded;
    logic [31:0]         off32;
    logic                outside;
    logic [SIZE_W-1:0]   init_cap, init_bytes;
    logic [KEY_W-1:0]    split_need;
    logic                do_split;
    logic [KEY_W-1:0]    grow_sum;
    logic [KEY_W-PG_SH-1:0] pages, pages_min;
    logic [KEY_W-1:0]    added_w;
    logic [KEY_W-1:0]    new_end;
    logic [SIZE_W-1:0]   lim;
    logic [CNT_W-1:0]    k_plus1;
    logic [SIZE_W-1:0]   take_amt;

    ffha_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .stat  (stat)
    );

    assign rounded  = (SIZE_W'(req_size) + SIZE_W'(7)) & ~SIZE_W'(7);
    assign off32    = free_addr - base_reg;
    assign outside  = (free_addr < base_reg) || (off32 >= 32'(end_reg));
    assign init_cap = (initial_reg > SPACE_CAP) ? SPACE_CAP : initial_reg;
    assign init_bytes = init_cap & ~SIZE_W'(PAGE_BYTES - 1);

    // A block is split only when the rest still holds a header and the minimum, and a table entry is spare.
    assign split_need = {1'b0, s_reg} + KEY_W'(HEADER_BYTES) + KEY_W'(min_split_reg);
    assign do_split   = ({1'b0, ent_reg.size} >= split_need) &&
                        (count_reg < CNT_W'(MAX_BLOCKS));
    assign take_amt   = do_split ? (s_reg + SIZE_W'(HEADER_BYTES))
                                 : ent_reg.size;

    // Growth is in whole pages, never fewer than four.
    assign grow_sum  = {1'b0, s_reg} + KEY_W'(HEADER_BYTES) + KEY_W'(PAGE_BYTES - 1);
    assign pages     = grow_sum[KEY_W-1:PG_SH];
    assign pages_min = (pages < (KEY_W-PG_SH)'(MIN_PAGES)) ? (KEY_W-PG_SH)'(MIN_PAGES)
                                                           : pages;
    assign added_w   = {pages_min, {PG_SH{1'b0}}};
    assign new_end   = {1'b0, end_reg} + {1'b0, added_reg};
    assign lim       = (limit_reg > SPACE_CAP) ? SPACE_CAP : limit_reg;
    assign k_plus1   = {1'b0, k_reg} + CNT_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        s_next       = s_reg;
        key_next     = key_reg;
        c_next       = c_reg;
        k_next       = k_reg;
        ent_next     = ent_reg;
        count_next   = count_reg;
        end_next     = end_reg;
        used_next    = used_reg;
        freet_next   = freet_reg;
        added_next   = added_reg;
        merge_r_next = merge_r_reg;
        shl_idx_next = shl_idx_reg;
        shl_n_next   = shl_n_reg;
        sts_next     = sts_reg;
        addr_next    = addr_reg;

        ctl        = '0;
        ctl.op     = CO_NONE;
        ctl.mode   = (cmd_reg == CMD_FREE) ? KM_MATCH : KM_FIT;
        ctl.key    = key_reg;
        ctl.rd_idx = c_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = cmd;
                    s_next    = rounded;
                    sts_next  = STS_OK;
                    addr_next = '0;
                    c_next    = '0;
                    state_next = S_FIN;
                    case (cmd)
                        CMD_ALLOC:
                        begin
                            if (req_size == '0)
                                sts_next = STS_ZERO;
                            else
                            begin
                                key_next   = {1'b0, rounded};
                                ctl.op     = CO_SCAN0;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (free_addr == '0)
                                sts_next = STS_OK;
                            else if (outside)
                                sts_next = STS_OUTSIDE;
                            else
                            begin
                                key_next   = off32[KEY_W-1:0];
                                ctl.op     = CO_SCAN0;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_INIT:
                        begin
                            // Initialization drops every block and starts over.
                            end_next  = init_bytes;
                            used_next = '0;
                            if (init_bytes > SIZE_W'(HEADER_BYTES))
                            begin
                                ctl.op         = CO_SHR;
                                ctl.idx        = '0;
                                ctl.wdata.off  = '0;
                                ctl.wdata.size = init_bytes - SIZE_W'(HEADER_BYTES);
                                ctl.wdata.free = 1'b1;
                                count_next     = CNT_W'(1);
                                freet_next     = init_bytes - SIZE_W'(HEADER_BYTES);
                            end
                            else
                            begin
                                count_next = '0;
                                freet_next = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_SCAN:
            begin
                if (c_reg >= count_reg)
                begin
                    if (cmd_reg == CMD_ALLOC)
                        state_next = S_GROW1;
                    else
                    begin
                        sts_next   = STS_NOTBLOCK;
                        state_next = S_FIN;
                    end
                end
                else if (stat.hit)
                begin
                    k_next     = c_reg[IDX_W-1:0];
                    ent_next   = stat.rd;
                    state_next = (cmd_reg == CMD_ALLOC) ? S_TAKE : S_FCHK;
                end
                else
                begin
                    ctl.op = CO_SCAN;
                    c_next = c_reg + CNT_W'(1);
                end
            end

            S_TAKE:
            begin
                ctl.op         = CO_WRITE;
                ctl.idx        = k_reg;
                ctl.wr_free    = 1'b1;
                ctl.wdata.free = 1'b0;
                ctl.wr_size    = do_split;
                ctl.wdata.size = s_reg;
                used_next  = used_reg + take_amt + (do_split ? '0 : SIZE_W'(HEADER_BYTES));
                freet_next = freet_reg - take_amt;
                addr_next  = base_reg + 32'(ent_reg.off) + 32'(HEADER_BYTES);
                state_next = do_split ? S_SPLIT : S_FIN;
            end

            S_SPLIT:
            begin
                ctl.op         = CO_SHR;
                ctl.idx        = k_plus1[IDX_W-1:0];
                ctl.wdata.off  = ent_reg.off + OFF_W'(HEADER_BYTES) + s_reg;
                ctl.wdata.size = ent_reg.size - s_reg - SIZE_W'(HEADER_BYTES);
                ctl.wdata.free = 1'b1;
                count_next     = count_reg + CNT_W'(1);
                state_next     = S_FIN;
            end

            S_GROW1:
            begin
                added_next = added_w[SIZE_W-1:0];
                state_next = S_GROW2;
            end

            S_GROW2:
            begin
                ctl.rd_idx = IDX_W'(count_reg - CNT_W'(1));
                if (new_end > {1'b0, lim})
                begin
                    sts_next   = STS_OOM;
                    state_next = S_FIN;
                end
                else if ((count_reg != '0) && stat.rd.free)
                begin
                    // The last block is free: it simply gets longer.
                    ctl.op         = CO_WRITE;
                    ctl.idx        = IDX_W'(count_reg - CNT_W'(1));
                    ctl.wr_size    = 1'b1;
                    ctl.wdata.size = stat.rd.size + added_reg;
                    k_next         = IDX_W'(count_reg - CNT_W'(1));
                    ent_next       = stat.rd;
                    ent_next.size  = stat.rd.size + added_reg;
                    end_next       = new_end[SIZE_W-1:0];
                    freet_next     = freet_reg + added_reg;
                    state_next     = S_TAKE;
                end
                else if (count_reg >= CNT_W'(MAX_BLOCKS))
                begin
                    sts_next   = STS_OOM;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.op         = CO_WRITE;
                    ctl.idx        = count_reg[IDX_W-1:0];
                    ctl.wr_off     = 1'b1;
                    ctl.wr_size    = 1'b1;
                    ctl.wr_free    = 1'b1;
                    ctl.wdata.off  = end_reg;
                    ctl.wdata.size = added_reg - SIZE_W'(HEADER_BYTES);
                    ctl.wdata.free = 1'b1;
                    k_next         = count_reg[IDX_W-1:0];
                    ent_next       = ctl.wdata;
                    count_next     = count_reg + CNT_W'(1);
                    end_next       = new_end[SIZE_W-1:0];
                    freet_next     = freet_reg + added_reg - SIZE_W'(HEADER_BYTES);
                    state_next     = S_TAKE;
                end
            end

            S_FCHK:
            begin
                if (ent_reg.free)
                begin
                    sts_next   = STS_DOUBLE;
                    state_next = S_FIN;
                end
                else
                begin
                    freet_next   = freet_reg + ent_reg.size;
                    used_next    = used_reg - ent_reg.size - SIZE_W'(HEADER_BYTES);
                    merge_r_next = 1'b0;
                    state_next   = S_FRIGHT;
                end
            end

            S_FRIGHT:
            begin
                ctl.rd_idx = k_plus1[IDX_W-1:0];
                if ((k_plus1 < count_reg) && stat.rd.free)
                begin
                    ent_next.size = ent_reg.size + SIZE_W'(HEADER_BYTES) + stat.rd.size;
                    freet_next    = freet_reg + SIZE_W'(HEADER_BYTES);
                    merge_r_next  = 1'b1;
                end
                state_next = S_FLEFT;
            end

            S_FLEFT:
            begin
                ctl.rd_idx  = k_reg - IDX_W'(1);
                ctl.op      = CO_WRITE;
                ctl.wr_size = 1'b1;
                if ((k_reg != '0) && stat.rd.free)
                begin
                    ctl.idx        = k_reg - IDX_W'(1);
                    ctl.wdata.size = stat.rd.size + SIZE_W'(HEADER_BYTES) + ent_reg.size;
                    freet_next     = freet_reg + SIZE_W'(HEADER_BYTES);
                    shl_idx_next   = k_reg;
                    shl_n_next     = merge_r_reg ? 2'd2 : 2'd1;
                    state_next     = S_SHIFTL;
                end
                else
                begin
                    ctl.idx        = k_reg;
                    ctl.wr_free    = 1'b1;
                    ctl.wdata.size = ent_reg.size;
                    ctl.wdata.free = 1'b1;
                    shl_idx_next   = k_plus1[IDX_W-1:0];
                    shl_n_next     = 2'd1;
                    state_next     = merge_r_reg ? S_SHIFTL : S_FIN;
                end
            end

            S_SHIFTL:
            begin
                ctl.op     = CO_SHL;
                ctl.idx    = shl_idx_reg;
                count_next = count_reg - CNT_W'(1);
                shl_n_next = shl_n_reg - 2'd1;
                if (shl_n_reg == 2'd1)
                    state_next = S_FIN;
            end

            S_FIN:
            begin
                state_next = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_ALLOC;
            s_reg         <= '0;
            key_reg       <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            ent_reg       <= '0;
            count_reg     <= '0;
            end_reg       <= '0;
            used_reg      <= '0;
            freet_reg     <= '0;
            added_reg     <= '0;
            merge_r_reg   <= 1'b0;
            shl_idx_reg   <= '0;
            shl_n_reg     <= '0;
            sts_reg       <= STS_OK;
            addr_reg      <= '0;
            done_reg      <= 1'b0;
            pa_reg        <= '0;
            st_reg        <= STS_OK;
            ub_reg        <= '0;
            fb_reg        <= '0;
            base_reg      <= '0;
            limit_reg     <= 25'd4194304;
            initial_reg   <= 25'd65536;
            min_split_reg <= 13'd16;
        end
        else
        begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            s_reg       <= s_next;
            key_reg     <= key_next;
            c_reg       <= c_next;
            k_reg       <= k_next;
            ent_reg     <= ent_next;
            count_reg   <= count_next;
            end_reg     <= end_next;
            used_reg    <= used_next;
            freet_reg   <= freet_next;
            added_reg   <= added_next;
            merge_r_reg <= merge_r_next;
            shl_idx_reg <= shl_idx_next;
            shl_n_reg   <= shl_n_next;
            sts_reg     <= sts_next;
            addr_reg    <= addr_next;

            // The result transfer is a one-cycle strobe after the final state.
            done_reg <= (state_reg == S_FIN);
            if (state_reg == S_FIN)
            begin
                pa_reg <= addr_reg;
                st_reg <= sts_reg;
                ub_reg <= used_reg;
                fb_reg <= freet_reg;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEAP_BASE: base_reg      <= cfg_data;
                    CFG_LIMIT:     limit_reg     <= cfg_data[24:0];
                    CFG_INITIAL:   initial_reg   <= cfg_data[24:0];
                    CFG_MIN_SPLIT: min_split_reg <= cfg_data[12:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign payload_addr = pa_reg;
    assign status       = st_reg;
    assign used_bytes   = ub_reg;
    assign free_bytes   = fb_reg;

    `ASSERT_IMPL(a_done_after_fin, clk, rst_n, done_reg, $past(state_reg == S_FIN))
    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(MAX_BLOCKS))
    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPL(a_shift_nonempty, clk, rst_n, state_reg == S_SHIFTL, count_reg != '0)

endmodule

>>> sim/ffha_checker.sv
// Scoreboard for the first-fit heap allocator: tracks its own copy of the block table.
// Depends on ffha_pkg; instantiated beside the block by tb_first_fit_heap_allocator_top.
`timescale 1ns / 1ps
module ffha_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  cmd,
    input  logic [23:0] req_size,
    input  logic [31:0] free_addr,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        done,
    input  logic [31:0] payload_addr,
    input  logic [2:0]  status,
    input  logic [24:0] used_bytes,
    input  logic [24:0] free_bytes,
    output int          errors,
    output int          pending
);
    import ffha_pkg::*;

    typedef struct packed {
        logic [31:0] addr;
        logic [2:0]  st;
        logic [24:0] used;
        logic [24:0] free;
    } heap_result_t;

    heap_result_t results_due[$];

    logic [31:0] base_r;
    logic [24:0] limit_r;
    logic [24:0] initial_r;
    logic [12:0] split_r;

    int unsigned blk_off[MAX_BLOCKS];
    int unsigned blk_len[MAX_BLOCKS];
    bit          blk_free[MAX_BLOCKS];
    int          n_blocks;
    int unsigned end_ofs;

    assign pending = results_due.size();

    function automatic void drop_block(int k);
        for (int i = k; i + 1 < n_blocks; i++)
        begin
            blk_off[i]  = blk_off[i + 1];
            blk_len[i]  = blk_len[i + 1];
            blk_free[i] = blk_free[i + 1];
        end
        n_blocks--;
    endfunction

    // Marks entry k allocated; a split needs room for the header plus the
    // minimum leftover and a spare table entry.
    function automatic void claim_block(int k, int unsigned sz);
        longint unsigned need;
        need = longint'(sz) + HEADER_BYTES + split_r;
        if (longint'(blk_len[k]) >= need && n_blocks < MAX_BLOCKS)
        begin
            for (int i = n_blocks; i > k + 1; i--)
            begin
                blk_off[i]  = blk_off[i - 1];
                blk_len[i]  = blk_len[i - 1];
                blk_free[i] = blk_free[i - 1];
            end
            blk_off[k + 1]  = blk_off[k] + HEADER_BYTES + sz;
            blk_len[k + 1]  = blk_len[k] - sz - HEADER_BYTES;
            blk_free[k + 1] = 1'b1;
            blk_len[k]      = sz;
            n_blocks++;
        end
        blk_free[k] = 1'b0;
    endfunction

    function automatic int grow_heap(int unsigned sz);
        longint unsigned pages, added, cap, new_end;
        pages = (longint'(sz) + HEADER_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
        if (pages < MIN_PAGES)
            pages = MIN_PAGES;
        added   = pages * PAGE_BYTES;
        cap     = (limit_r > SPACE_CAP) ? SPACE_CAP : limit_r;
        new_end = longint'(end_ofs) + added;
        if (new_end > cap)
            return -1;
        if (n_blocks > 0 && blk_free[n_blocks - 1])
            blk_len[n_blocks - 1] += int'(added);
        else
        begin
            if (n_blocks >= MAX_BLOCKS)
                return -1;
            blk_off[n_blocks]  = end_ofs;
            blk_len[n_blocks]  = int'(added) - HEADER_BYTES;
            blk_free[n_blocks] = 1'b1;
            n_blocks++;
        end
        end_ofs = int'(new_end);
        return n_blocks - 1;
    endfunction

    function automatic heap_result_t predict_heap(logic [1:0] c, logic [23:0] r,
                                                  logic [31:0] a);
        heap_result_t res;
        int           k;
        int unsigned  sz, used, fr;
        longint unsigned ofs, bytes;
        res = '0;
        res.st = STS_OK;
        if (c == CMD_ALLOC)
        begin
            if (r == 0)
                res.st = STS_ZERO;
            else
            begin
                sz = (int'(r) + 7) & ~32'd7;
                k = -1;
                for (int i = 0; i < n_blocks; i++)
                    if (k < 0 && blk_free[i] && blk_len[i] >= sz)
                        k = i;
                if (k < 0)
                    k = grow_heap(sz);
                if (k < 0)
                    res.st = STS_OOM;
                else
                begin
                    claim_block(k, sz);
                    res.addr = base_r + blk_off[k] + HEADER_BYTES;
                end
            end
        end
        else if (c == CMD_FREE)
        begin
            if (a == 0)
                res.st = STS_OK;
            else if (a < base_r)
                res.st = STS_OUTSIDE;
            else
            begin
                ofs = longint'(a) - longint'(base_r);
                if (ofs >= end_ofs)
                    res.st = STS_OUTSIDE;
                else
                begin
                    k = -1;
                    for (int i = 0; i < n_blocks; i++)
                        if (k < 0 && longint'(blk_off[i]) + HEADER_BYTES == ofs)
                            k = i;
                    if (k < 0)
                        res.st = STS_NOTBLOCK;
                    else if (blk_free[k])
                        res.st = STS_DOUBLE;
                    else
                    begin
                        blk_free[k] = 1'b1;
                        k = 0;
                        while (k + 1 < n_blocks)
                        begin
                            if (blk_free[k] && blk_free[k + 1])
                            begin
                                blk_len[k] += HEADER_BYTES + blk_len[k + 1];
                                drop_block(k + 1);
                            end
                            else
                                k++;
                        end
                    end
                end
            end
        end
        else if (c == CMD_INIT)
        begin
            bytes = (initial_r > SPACE_CAP) ? SPACE_CAP : initial_r;
            bytes = (bytes / PAGE_BYTES) * PAGE_BYTES;
            end_ofs = int'(bytes);
            if (bytes > HEADER_BYTES)
            begin
                blk_off[0]  = 0;
                blk_len[0]  = int'(bytes) - HEADER_BYTES;
                blk_free[0] = 1'b1;
                n_blocks    = 1;
            end
            else
                n_blocks = 0;
        end
        used = 0;
        fr   = 0;
        for (int i = 0; i < n_blocks; i++)
            if (blk_free[i])
                fr += blk_len[i];
            else
                used += blk_len[i] + HEADER_BYTES;
        res.used = used[24:0];
        res.free = fr[24:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        heap_result_t want;
        heap_result_t got;
        if (!rst_n)
        begin
            base_r    = 32'd0;
            limit_r   = 25'd4194304;
            initial_r = 25'd65536;
            split_r   = 13'd16;
            n_blocks  = 0;
            end_ofs   = 0;
            errors    = 0;
            results_due.delete();
        end
        else
        begin
            // The result of an earlier command is compared before a new
            // command transfer on the same edge is predicted.
            if (done)
            begin
                got = {payload_addr, status, used_bytes, free_bytes};
                if (results_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%t: result with nothing outstanding: addr %h status %0d",
                                 $realtime, payload_addr, status);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (want != got)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%t: exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                                     $realtime, want.addr, want.st, want.used, want.free,
                                     got.addr, got.st, got.used, got.free);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEAP_BASE: base_r    = cfg_data;
                    CFG_LIMIT:     limit_r   = cfg_data[24:0];
                    CFG_INITIAL:   initial_r = cfg_data[24:0];
                    CFG_MIN_SPLIT: split_r   = cfg_data[12:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                results_due.push_back(predict_heap(cmd, req_size, free_addr));
        end
    end

endmodule

>>> sim/tb_first_fit_heap_allocator_top.sv
// Testbench top for the first-fit heap allocator: clock, reset, stimulus and verdict.
// Depends on ffha_pkg, first_fit_heap_allocator_top and ffha_checker.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator_top;
    import ffha_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [23:0] req_size;
    logic [31:0] free_addr;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        done;
    logic [31:0] payload_addr;
    logic [2:0]  status;
    logic [24:0] used_bytes;
    logic [24:0] free_bytes;
    int          errors;
    int          pending;

    // Addresses handed out by the block; frees are mostly drawn from here so
    // that they reach the coalescing logic instead of failing the checks.
    logic [31:0] live_addrs[$];
    logic [31:0] last_freed;
    logic [31:0] cur_base;
    int          sent;
    int          returned;
    bit          calm;

    first_fit_heap_allocator_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .req_size(req_size), .free_addr(free_addr),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .payload_addr(payload_addr), .status(status),
        .used_bytes(used_bytes), .free_bytes(free_bytes)
    );

    ffha_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .req_size(req_size), .free_addr(free_addr),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .payload_addr(payload_addr), .status(status),
        .used_bytes(used_bytes), .free_bytes(free_bytes),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watch result transfers to count them and to learn the granted addresses.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            returned++;
            if (payload_addr != 0)
                live_addrs.push_back(payload_addr);
        end
    end

    // One command transfer. The task is entered on the edge that accepted the
    // previous command; with no gap start simply stays high so that it is
    // never lowered and raised in the same step.
    task automatic send_cmd(logic [1:0] c, logic [23:0] r, logic [31:0] a);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        cmd       <= c;
        req_size  <= r;
        free_addr <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    // Waits until every result is back and the block is idle.
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (returned != sent || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_heap(logic [31:0] base, logic [31:0] lim, logic [31:0] init_sz,
                            logic [31:0] split);
        drain();
        write_reg(CFG_HEAP_BASE, base);
        write_reg(CFG_LIMIT, lim);
        write_reg(CFG_INITIAL, init_sz);
        write_reg(CFG_MIN_SPLIT, split);
        cur_base = base;
    endtask

    function automatic logic [23:0] pick_size;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 24'($urandom_range(1, 256));
        else if (roll < 85)
            return 24'($urandom_range(257, 8192));
        else if (roll < 95)
            return 24'($urandom_range(8193, 200000));
        else if (roll < 99)
            return 24'd0;
        return 24'($urandom);
    endfunction

    // Frees mostly target live blocks; the rest are repeats of the last freed
    // address, misaligned or out-of-range addresses, and null.
    task automatic random_free;
        int          roll;
        int          idx;
        logic [31:0] a;
        roll = $urandom_range(0, 99);
        if (roll < 65 && live_addrs.size() > 0)
        begin
            idx = $urandom_range(0, live_addrs.size() - 1);
            a = live_addrs[idx];
            live_addrs.delete(idx);
            last_freed = a;
        end
        else if (roll < 78)
            a = last_freed;
        else if (roll < 88)
            a = cur_base + $urandom_range(0, 70000);
        else if (roll < 96)
            a = $urandom;
        else
            a = 32'd0;
        send_cmd(CMD_FREE, 24'($urandom), a);
    endtask

    task automatic run_phase(int count, int free_pct);
        int roll;
        send_cmd(CMD_INIT, 24'($urandom), $urandom);
        live_addrs.delete();
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                calm = ~calm;
            roll = $urandom_range(0, 99);
            if (roll < free_pct)
                random_free();
            else if (roll < 97)
                send_cmd(CMD_ALLOC, pick_size(), $urandom);
            else if (roll < 98)
                send_cmd(CMD_UNUSED, 24'($urandom), $urandom);
            else
            begin
                send_cmd(CMD_INIT, 24'($urandom), $urandom);
                live_addrs.delete();
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = CMD_ALLOC;
        req_size  = '0;
        free_addr = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_HEAP_BASE;
        cfg_data  = '0;
        sent      = 0;
        returned  = 0;
        calm      = 1'b0;
        cur_base  = 32'd0;
        last_freed = 32'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset configuration. An allocate before any
        // initialize grows the empty heap from offset zero.
        send_cmd(CMD_ALLOC, 24'd5, 32'd0);
        send_cmd(CMD_INIT, 24'd0, 32'd0);
        send_cmd(CMD_ALLOC, 24'd0, 32'd0);
        send_cmd(CMD_ALLOC, 24'd1, 32'd0);
        send_cmd(CMD_ALLOC, 24'hFF_FFFF, 32'd0);
        send_cmd(CMD_ALLOC, 24'd8, 32'd0);
        send_cmd(CMD_ALLOC, 24'd70000, 32'd0);
        send_cmd(CMD_FREE, 24'd0, 32'd0);
        send_cmd(CMD_FREE, 24'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_FREE, 24'd0, 32'd21);
        send_cmd(CMD_FREE, 24'd0, 32'd20);
        send_cmd(CMD_FREE, 24'd0, 32'd20);
        send_cmd(CMD_FREE, 24'd0, 32'd48);
        send_cmd(CMD_UNUSED, 24'hFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_ALLOC, 24'd4000, 32'd0);

        // Base below zero offset and a limit too small for any growth.
        set_heap(32'hFFFF_F000, 32'd4096, 32'd4096, 32'd0);
        send_cmd(CMD_FREE, 24'd0, 32'd1);
        run_phase(250, 40);
        set_heap(32'd0, 32'd16777216, 32'd65536, 32'd16);
        run_phase(300, 45);
        // Register values above the address space are capped by the block.
        set_heap($urandom, 32'h1FF_FFFF, 32'h1FF_FFFF, 32'd4096);
        run_phase(250, 45);
        // Mostly allocations of small blocks fill the table.
        set_heap($urandom, 32'd1048576, 32'd16384, 32'd0);
        run_phase(350, 15);
        set_heap(32'h8000_0000, 32'd16777216, 32'd4096, 32'h1FFF);
        run_phase(300, 45);
        set_heap($urandom, $urandom_range(4096, 16777216), $urandom_range(4096, 16777216),
                 $urandom_range(0, 4096));
        run_phase(350, 40);

        drain();
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_first_fit_heap_allocator_top: clean");
        else
            $display("tb_first_fit_heap_allocator_top: errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_first_fit_heap_allocator_top: errors");
        $finish;
    end

endmodule
